// ===== hdl/rmtsf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmtsf_pkg
// shared constants, types and helpers for the record multi-term search filter
// ----------------------------------------------------------------------------
package rmtsf_pkg;

    localparam int QUERY_CHARS       = 32;
    localparam int FIELDS_PER_RECORD = 5;

    // match vector width: query limited to the 32 characters the registers hold
    localparam int MATCH_BITS  = (QUERY_CHARS < 32) ? QUERY_CHARS : 32;
    localparam int QUERY_WORDS = 4;
    localparam int QLEN_W      = 6;
    localparam int FP_W        = $clog2(FIELDS_PER_RECORD);
    localparam int CNT_W       = 16;
    localparam int PDATA_W     = 64;
    localparam int PADDR_W     = 6;
    localparam int REG_IDX_W   = 3;

    localparam logic [FP_W-1:0] FP_LAST = FP_W'(FIELDS_PER_RECORD - 1);

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_Z  = 8'h5a;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    localparam logic [7:0] RSEP_RESET = 8'h0a;
    localparam logic [7:0] FSEP_RESET = 8'h09;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_QUERY_LOW    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_QUERY_SECOND = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_QUERY_THIRD  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_QUERY_HIGH   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_QUERY_LENGTH = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_RECORD_SEP   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_FIELD_SEP    = 3'd6;

    // query view derived from the configuration registers
    typedef struct packed {
        logic [MATCH_BITS-1:0][7:0] qchar;   // case-folded query characters
        logic [MATCH_BITS-1:0]      live;    // used and not a space
        logic [MATCH_BITS-1:0]      starts;  // first character of a term
        logic [MATCH_BITS-1:0]      ends;    // last character of a term
        logic [7:0]                 rsep;
        logic [7:0]                 fsep;
    } t_query_cfg;

    typedef struct packed {
        logic             line_end;
        logic             valid;
        logic             matched;
        logic [CNT_W-1:0] number;
    } t_scan_res;

    function automatic logic [7:0] fold_char(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
            r = c | CASE_BIT;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/rmtsf_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmtsf_cfg
// apb register file and derived query term masks
// ----------------------------------------------------------------------------
module rmtsf_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rmtsf_pkg::PADDR_W-1:0] paddr,
    input  wire logic [rmtsf_pkg::PDATA_W-1:0] pwdata,
    output logic      [rmtsf_pkg::PDATA_W-1:0] prdata,
    output logic                               pready,
    output rmtsf_pkg::t_query_cfg              o_cfg
);
    import rmtsf_pkg::*;

    logic [QUERY_WORDS-1:0][PDATA_W-1:0] r_qword;
    logic [QLEN_W-1:0]                   r_qlen;
    logic [7:0]                          r_rsep;
    logic [7:0]                          r_fsep;

    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qword <= '0;
            r_qlen  <= '0;
            r_rsep  <= RSEP_RESET;
            r_fsep  <= FSEP_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_QUERY_LOW:    r_qword[0] <= pwdata;
                REG_QUERY_SECOND: r_qword[1] <= pwdata;
                REG_QUERY_THIRD:  r_qword[2] <= pwdata;
                REG_QUERY_HIGH:   r_qword[3] <= pwdata;
                REG_QUERY_LENGTH: r_qlen     <= pwdata[QLEN_W-1:0];
                REG_RECORD_SEP:   r_rsep     <= pwdata[7:0];
                REG_FIELD_SEP:    r_fsep     <= pwdata[7:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_QUERY_LOW:    prdata = r_qword[0];
            REG_QUERY_SECOND: prdata = r_qword[1];
            REG_QUERY_THIRD:  prdata = r_qword[2];
            REG_QUERY_HIGH:   prdata = r_qword[3];
            REG_QUERY_LENGTH: prdata = PDATA_W'(r_qlen);
            REG_RECORD_SEP:   prdata = PDATA_W'(r_rsep);
            REG_FIELD_SEP:    prdata = PDATA_W'(r_fsep);
            default:          prdata = '0;
        endcase
    end

    // term masks from the query characters and the clamped length
    logic [QLEN_W-1:0]       n_used;
    logic [MATCH_BITS:0]     used;
    logic [MATCH_BITS:0]     space;
    logic [MATCH_BITS-1:0][7:0] raw;

    always_comb begin
        n_used = (r_qlen > QLEN_W'(MATCH_BITS)) ? QLEN_W'(MATCH_BITS) : r_qlen;
        used   = '0;
        space  = '0;
        for (int i = 0; i < MATCH_BITS; i++) begin
            raw[i]   = r_qword[i / 8][(i % 8) * 8 +: 8];
            used[i]  = QLEN_W'(i) < n_used;
            space[i] = raw[i] == CHAR_SPACE;
        end
        for (int i = 0; i < MATCH_BITS; i++) begin
            o_cfg.qchar[i]  = fold_char(raw[i]);
            o_cfg.live[i]   = used[i] && !space[i];
            o_cfg.starts[i] = used[i] && !space[i] && ((i == 0) || space[(i == 0) ? 0 : i - 1]);
            o_cfg.ends[i]   = used[i] && !space[i] && (!used[i + 1] || space[i + 1]);
        end
        o_cfg.rsep = r_rsep;
        o_cfg.fsep = r_fsep;
    end

endmodule
`default_nettype wire

// ===== hdl/rmtsf_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmtsf_scan
// per-byte field tracking, shift-and term matching and record counting
// ----------------------------------------------------------------------------
module rmtsf_scan (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  rmtsf_pkg::t_query_cfg      i_cfg,
    input  wire logic                  i_valid,
    input  wire logic                  i_en,
    input  wire logic [7:0]            i_byte,
    input  wire logic                  i_last,
    output rmtsf_pkg::t_scan_res       o_res
);
    import rmtsf_pkg::*;

    logic [MATCH_BITS-1:0] r_pm, n_pm;
    logic [MATCH_BITS-1:0] r_th, n_th;
    logic [FP_W-1:0]       r_fp, n_fp;
    logic                  r_lne, n_lne;
    logic [CNT_W-1:0]      r_cnt, n_cnt;

    logic [MATCH_BITS-1:0] hits;
    logic [7:0]            c_fold;
    logic                  searched;

    always_comb begin
        c_fold   = fold_char(i_byte);
        searched = (r_fp == FP_LAST) || (32'(r_fp) < 3);
        for (int i = 0; i < MATCH_BITS; i++) begin
            hits[i] = i_cfg.live[i] && (i_cfg.qchar[i] == c_fold);
        end

        n_pm  = r_pm;
        n_th  = r_th;
        n_fp  = r_fp;
        n_lne = r_lne;
        n_cnt = r_cnt;

        o_res.line_end = i_last || (i_byte == i_cfg.rsep);
        o_res.valid    = 1'b0;
        o_res.matched  = 1'b0;
        o_res.number   = r_cnt;

        if (i_byte != i_cfg.rsep) begin
            n_lne = 1'b1;
            if (i_byte == i_cfg.fsep && r_fp < FP_LAST) begin
                n_fp = r_fp + 1'b1;
                n_pm = '0;
            end else if (searched) begin
                n_pm = ((r_pm << 1) | i_cfg.starts) & hits;
                n_th = r_th | (n_pm & i_cfg.ends);
            end else begin
                n_pm = '0;
            end
        end

        if (o_res.line_end) begin
            o_res.valid   = i_valid && n_lne && (n_fp == FP_LAST);
            o_res.matched = (i_cfg.ends != '0) && ((n_th & i_cfg.ends) == i_cfg.ends);
            if (n_lne && n_fp == FP_LAST) begin
                n_cnt = r_cnt + 1'b1;
            end
            n_pm  = '0;
            n_th  = '0;
            n_fp  = '0;
            n_lne = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pm  <= '0;
            r_th  <= '0;
            r_fp  <= '0;
            r_lne <= 1'b0;
            r_cnt <= '0;
        end else if (i_en) begin
            r_pm  <= n_pm;
            r_th  <= n_th;
            r_fp  <= n_fp;
            r_lne <= n_lne;
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/record_multi_term_search_filter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// a record's result is loaded into the output register when its closing byte is consumed from the input register
// throughput: one index byte per cycle, set by the combinational shift-and update of the scan state
// a line-ending byte waits in the input register only while a result is stalled
// reset (synchronous, active low) empties both registers, clears the line state and the
// record counter, and returns the query to empty with newline and tab as separators
// ----------------------------------------------------------------------------
// record_multi_term_search_filter_core
// streams index bytes, splits records into fields and flags records in which
// every space-separated query term occurs, case-folded, in a searched field
// ----------------------------------------------------------------------------
module record_multi_term_search_filter_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rmtsf_pkg::PADDR_W-1:0] paddr,
    input  wire logic [rmtsf_pkg::PDATA_W-1:0] pwdata,
    output logic      [rmtsf_pkg::PDATA_W-1:0] prdata,
    output logic                               pready,
    // index byte channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [7:0]                    i_index_byte,
    input  wire logic                          i_end_of_index,
    // result channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_matched,
    output logic [rmtsf_pkg::CNT_W-1:0]        o_record_number
);
    import rmtsf_pkg::*;

    t_query_cfg cfg;
    t_scan_res  res;

    // input register
    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_last;

    // result register
    logic             r_out_valid;
    logic             r_out_matched;
    logic [CNT_W-1:0] r_out_number;

    logic out_free;   // result register can take a new transaction
    logic proc;       // input register item is consumed by the scan this cycle
    logic in_take;

    rmtsf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rmtsf_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (r_s1_valid),
        .i_en    (proc),
        .i_byte  (r_s1_byte),
        .i_last  (r_s1_last),
        .o_res   (res)
    );

    // only a line end can make a result, so only a line end waits on the output side
    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc       = r_s1_valid && (!res.line_end || out_free);
    assign o_in_stall = r_s1_valid && !proc;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    // input payload, held while stalled
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_byte <= i_index_byte;
            r_s1_last <= i_end_of_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= proc && res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && res.valid) begin
            r_out_matched <= res.matched;
            r_out_number  <= res.number;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_matched       = r_out_matched;
    assign o_record_number = r_out_number;

`ifndef NO_ASSERTIONS
    // a stall on the input side only comes from a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a stalled result");

    // bytes inside a line never wait
    a_mid_line_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !res.line_end) |-> !o_in_stall)
        else $error("mid-line byte stalled");

    // a completed record shows up on the result register
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && res.valid) |=> o_out_valid)
        else $error("record result lost");
`endif

endmodule
`default_nettype wire
